### hw/rtl/running_median_tracker_assert.svh
// Assertion macros for the running median tracker.
// Included by the top level; no other dependencies.
`ifndef RUNNING_MEDIAN_TRACKER_ASSERT_SVH
`define RUNNING_MEDIAN_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define RMT_ASSERT_NOW(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("rmt assertion failed");
`define RMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmt assertion failed");
`else
`define RMT_ASSERT_NOW(lbl, clk, rst_n, cond)
`define RMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/rmt_pkg.sv
// Shared types and constants for the running median tracker.
// No dependencies.
package rmt_pkg;

    localparam int SAMPLE_PORT_W = 32;
    localparam int MEDIAN_W      = 33;
    localparam int COUNT_W       = 11;

    typedef enum logic [3:0] {
        OP_HOLD    = 4'b0001,
        OP_INS     = 4'b0010,
        OP_PUSH    = 4'b0100,
        OP_POP_INS = 4'b1000
    } t_op;

    typedef struct packed {
        t_op  op;
        logic valid;
        logic at_end;
    } t_cell_ctl;

endpackage

### hw/rtl/rmt_cell.sv
// One storage cell of a sorted half: holds one sample, swaps with neighbours.
// Depends on rmt_pkg.
module rmt_cell #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  rmt_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_desc,
    input  logic signed [W-1:0]   i_v,
    input  logic signed [W-1:0]   i_prev_x,
    input  logic                  i_prev_bf,
    input  logic signed [W-1:0]   i_next_x,
    input  logic                  i_next_nb,
    output logic signed [W-1:0]   o_x,
    output logic signed [W-1:0]   o_x_next,
    output logic                  o_bf,
    output logic                  o_nb
);

    logic signed [W-1:0] r_x;
    logic signed [W-1:0] n_x;
    logic                beyond;

    // beyond: this entry sorts after v
    always_comb begin
        beyond = i_desc ? (r_x < i_v) : (r_x > i_v);
        o_bf   = i_ctl.valid & beyond;
        o_nb   = i_ctl.valid & ~beyond;
    end

    always_comb begin
        n_x = r_x;
        case (i_ctl.op)
            rmt_pkg::OP_INS: begin
                if (i_ctl.valid || i_ctl.at_end) begin
                    if (i_prev_bf) begin
                        n_x = i_prev_x;
                    end else if (o_bf || i_ctl.at_end) begin
                        n_x = i_v;
                    end
                end
            end
            rmt_pkg::OP_PUSH: begin
                if (i_ctl.valid || i_ctl.at_end) begin
                    n_x = i_prev_x;
                end
            end
            rmt_pkg::OP_POP_INS: begin
                if (i_ctl.valid) begin
                    if (i_next_nb) begin
                        n_x = i_next_x;
                    end else if (o_nb) begin
                        n_x = i_v;
                    end
                end
            end
            rmt_pkg::OP_HOLD: begin
                n_x = r_x;
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    assign o_x      = r_x;
    assign o_x_next = n_x;

endmodule

### hw/rtl/rmt_chain.sv
// One sorted half of the store as a row of rmt_cell, front at cell 0.
// Depends on rmt_pkg and rmt_cell.
module rmt_chain #(
    parameter int DEPTH = 512,
    parameter int W     = 32,
    parameter int SW    = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  rmt_pkg::t_op          i_op,
    input  logic                  i_desc,
    input  logic [SW-1:0]         i_size,
    input  logic signed [W-1:0]   i_v,
    input  logic signed [W-1:0]   i_push,
    output logic signed [W-1:0]   o_front,
    output logic signed [W-1:0]   o_front_next
);

    logic signed [W-1:0] xx  [0:DEPTH+1];
    logic signed [W-1:0] xn  [0:DEPTH-1];
    logic                bfa [0:DEPTH];
    logic                nba [0:DEPTH];

    assign xx[0]       = i_push;
    assign xx[DEPTH+1] = xx[DEPTH];
    assign bfa[0]      = 1'b0;
    assign nba[DEPTH]  = 1'b0;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        rmt_pkg::t_cell_ctl ctl;

        always_comb begin
            ctl.op     = i_op;
            ctl.valid  = (i_size > SW'(j));
            ctl.at_end = (i_size == SW'(j));
        end

        rmt_cell #(.W(W)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_desc    (i_desc),
            .i_v       (i_v),
            .i_prev_x  (xx[j]),
            .i_prev_bf (bfa[j]),
            .i_next_x  (xx[j+2]),
            .i_next_nb (nba[j+1]),
            .o_x       (xx[j+1]),
            .o_x_next  (xn[j]),
            .o_bf      (bfa[j+1]),
            .o_nb      (nba[j])
        );
    end

    assign o_front      = xx[1];
    assign o_front_next = xn[0];

endmodule

### hw/rtl/running_median_tracker.sv
// Running median tracker. Each accepted item inserts one signed sample (unless the store is full) into a
// store split into a lower half (descending, front = largest) and an upper half
// (ascending, front = smallest), each a row of cells that shift together.
// One item per cycle unless the output holds off o_in_ready; the result is
// registered and valid in the cycle after acceptance. Reports twice the median,
// the count held and a reject flag when the store is full (sample dropped).
// Depends on rmt_pkg, rmt_chain and running_median_tracker_assert.svh.
`include "running_median_tracker_assert.svh"

module running_median_tracker #(
    parameter int CAPACITY     = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [rmt_pkg::SAMPLE_PORT_W-1:0]      i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [rmt_pkg::MEDIAN_W-1:0]    o_median_twice,
    output logic [rmt_pkg::COUNT_W-1:0]            o_stored_count,
    output logic                                   o_rejected
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LDEPTH = (CAPACITY + 1) / 2;
    localparam int UDEPTH = CAPACITY / 2;
    localparam int LSW    = $clog2(LDEPTH + 1);
    localparam int USW    = $clog2(UDEPTH + 1);
    localparam int W      = SAMPLE_WIDTH;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic signed [rmt_pkg::MEDIAN_W-1:0] r_median;
    logic [rmt_pkg::COUNT_W-1:0]         r_cnt_out;
    logic                r_rej;

    logic                accept;
    logic                full;
    logic                even;
    logic                empty;
    logic                take;
    logic signed [W-1:0] v;
    logic [CW:0]         count_p1;
    logic [LSW-1:0]      l_size;
    logic [USW-1:0]      u_size;
    rmt_pkg::t_op        l_op;
    rmt_pkg::t_op        u_op;
    logic signed [W-1:0] l_front;
    logic signed [W-1:0] u_front;
    logic signed [W-1:0] l_front_next;
    logic signed [W-1:0] u_front_next;
    logic signed [W:0]   med_sum;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign v          = $signed(i_sample[W-1:0]);
    assign full       = (r_count == CW'(CAPACITY));
    assign even       = ~r_count[0];
    assign empty      = (r_count == '0);
    assign take       = accept & ~full;
    assign count_p1   = {1'b0, r_count} + (CW+1)'(1);
    assign l_size     = LSW'(count_p1 >> 1);
    assign u_size     = USW'(r_count >> 1);
    assign n_count    = take ? CW'(count_p1) : r_count;

    always_comb begin
        l_op = rmt_pkg::OP_HOLD;
        u_op = rmt_pkg::OP_HOLD;
        if (take) begin
            if (even) begin
                if (empty || (v <= u_front)) begin
                    l_op = rmt_pkg::OP_INS;
                end else begin
                    l_op = rmt_pkg::OP_PUSH;
                    u_op = rmt_pkg::OP_POP_INS;
                end
            end else begin
                if (v >= l_front) begin
                    u_op = rmt_pkg::OP_INS;
                end else begin
                    u_op = rmt_pkg::OP_PUSH;
                    l_op = rmt_pkg::OP_POP_INS;
                end
            end
        end
    end

    rmt_chain #(.DEPTH(LDEPTH), .W(W)) u_lower (
        .i_clk        (i_clk),
        .i_op         (l_op),
        .i_desc       (1'b1),
        .i_size       (l_size),
        .i_v          (v),
        .i_push       (u_front),
        .o_front      (l_front),
        .o_front_next (l_front_next)
    );

    rmt_chain #(.DEPTH(UDEPTH), .W(W)) u_upper (
        .i_clk        (i_clk),
        .i_op         (u_op),
        .i_desc       (1'b0),
        .i_size       (u_size),
        .i_v          (v),
        .i_push       (l_front),
        .o_front      (u_front),
        .o_front_next (u_front_next)
    );

    // odd count: twice the lower front; even: sum of both fronts
    assign med_sum = n_count[0] ? {l_front_next, 1'b0}
                                : ({l_front_next[W-1], l_front_next}
                                   + {u_front_next[W-1], u_front_next});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_median  <= rmt_pkg::MEDIAN_W'(med_sum);
            r_cnt_out <= rmt_pkg::COUNT_W'(n_count);
            r_rej     <= full;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_twice = r_median;
    assign o_stored_count = r_cnt_out;
    assign o_rejected     = r_rej;

    `RMT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `RMT_ASSERT_NEXT(a_full_rejects, i_clk, i_rst_n, accept && full, o_rejected && r_count == $past(r_count))
    `RMT_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, accept && !full, r_count == $past(r_count) + CW'(1))
    `RMT_ASSERT_NOW(a_halves_ordered, i_clk, i_rst_n, (r_count < CW'(2)) || (l_front <= u_front))

endmodule

### tb/running_median_tracker_tb.sv
// Self-checking testbench for running_median_tracker: sorted-store median predictor,
// directed extremes and duplicates, then random streams under varying back-pressure.
// Depends on rmt_pkg and the running_median_tracker RTL.
module running_median_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH    = 1024;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 410;

    typedef struct {
        logic signed [rmt_pkg::MEDIAN_W-1:0] median_twice;
        logic [rmt_pkg::COUNT_W-1:0]         stored_count;
        logic                                rejected;
    } t_median_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic [rmt_pkg::SAMPLE_PORT_W-1:0]   i_sample;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic signed [rmt_pkg::MEDIAN_W-1:0] o_median_twice;
    logic [rmt_pkg::COUNT_W-1:0]         o_stored_count;
    logic                                o_rejected;

    int             sorted_store[$];
    t_median_result pending_medians[$];
    int             send_idle_pct;
    int             recv_idle_pct;
    int             err_count;
    int             quiet_cycles;

    running_median_tracker #(
        .CAPACITY     (STORE_DEPTH),
        .SAMPLE_WIDTH (32)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_median_twice (o_median_twice),
        .o_stored_count (o_stored_count),
        .o_rejected     (o_rejected)
    );

    always #10 i_clk = ~i_clk;

    // Inserts after equal entries unless the store is full, then takes twice the median of what is held.
    function automatic t_median_result predict_median(logic signed [31:0] s);
        t_median_result r;
        int             pos;
        int             n;
        longint         m;
        r.rejected = 1'b0;
        if (sorted_store.size() >= STORE_DEPTH) begin
            r.rejected = 1'b1;
        end else begin
            pos = sorted_store.size();
            while (pos > 0 && sorted_store[pos-1] > int'(s)) pos--;
            sorted_store.insert(pos, int'(s));
        end
        n = sorted_store.size();
        if (n % 2 == 1) begin
            m = 2 * longint'(sorted_store[n/2]);
        end else begin
            m = longint'(sorted_store[n/2-1]) + longint'(sorted_store[n/2]);
        end
        r.median_twice = m[rmt_pkg::MEDIAN_W-1:0];
        r.stored_count = n[rmt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic send_sample(input logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_medians.push_back(predict_median(s));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        logic [31:0] s;
        case ($urandom_range(9))
            5, 6:    s = $urandom_range(32) - 16;
            7: begin
                case ($urandom_range(3))
                    0:       s = 32'h8000_0000;
                    1:       s = 32'h7FFF_FFFF;
                    2:       s = 32'h0000_0000;
                    default: s = 32'hFFFF_FFFF;
                endcase
            end
            8: begin
                if (sorted_store.size() != 0)
                    s = sorted_store[$urandom_range(sorted_store.size() - 1)];
                else
                    s = $urandom;
            end
            9:       s = ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFF0) + $urandom_range(15);
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic test_extremes();
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        repeat (4) send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample(32'h5555_5555);
        send_sample(32'hAAAA_AAAA);
    endtask

    task automatic test_equal_samples();
        repeat (3) send_sample(32'd7);
        send_sample(-32'sd7);
        repeat (2) send_sample(32'd7);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_random_stream(input int items, input int tx_idle, input int rx_idle);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        repeat (items) send_sample(pick_sample());
        wait_for_drain();
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_median_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_medians.size() == 0) begin
                $error("unexpected result: median_twice %0d count %0d",
                       o_median_twice, o_stored_count);
                err_count++;
            end else begin
                want = pending_medians.pop_front();
                if (o_median_twice !== want.median_twice) begin
                    $error("median_twice: expected %0d, got %0d",
                           want.median_twice, o_median_twice);
                    err_count++;
                end
                if (o_stored_count !== want.stored_count) begin
                    $error("stored_count: expected %0d, got %0d",
                           want.stored_count, o_stored_count);
                    err_count++;
                end
                if (o_rejected !== want.rejected) begin
                    $error("rejected: expected %0b, got %0b", want.rejected, o_rejected);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("running_median_tracker_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_sample      = '0;
        i_out_ready   = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 49;
        err_count     = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_equal_samples();
        wait_for_drain();
        test_random_stream(PHASE_ITEMS, 12, 49);
        test_random_stream(PHASE_ITEMS, 49, 12);
        // store fills part-way through this one; the rest are rejected
        test_random_stream(PHASE_ITEMS, 0, 0);

        repeat (8) @(posedge i_clk);
        if (pending_medians.size() != 0) begin
            $error("%0d results never arrived", pending_medians.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("running_median_tracker_tb: PASS");
        end else begin
            $display("running_median_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule
